@@ src/dtrf_pkg.sv @@
// Shared types, codes and constants for the double to retro float converter.
package dtrf_pkg;

    localparam int MaxMantissa = 7;

    typedef enum logic [2:0] {
        MODE_GENERIC = 3'd0,
        MODE_IEEE32  = 3'd1,
        MODE_MBF32   = 3'd2,
        MODE_MBF40   = 3'd3,
        MODE_MBF64   = 3'd4,
        MODE_IEEE16  = 3'd5,
        MODE_AM9511  = 3'd6,
        MODE_SPARE   = 3'd7
    } fmt_mode_t;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_BIAS   = 2'd1;
    localparam logic [1:0] REG_MBYTES = 2'd2;
    localparam logic [1:0] REG_OFFSET = 2'd3;

    typedef struct packed {
        fmt_mode_t   mode;
        logic [7:0]  bias;
        logic [2:0]  mbytes;
        logic        offset;
    } cfg_t;

    localparam logic [31:0] IEEE32_NAN     = 32'h7fc00000;
    localparam logic [31:0] IEEE32_PINF    = 32'h7f800000;
    localparam logic [31:0] IEEE32_NINF    = 32'hff800000;
    localparam logic [15:0] IEEE16_NAN     = 16'hffff;
    localparam logic [15:0] IEEE16_PINF    = 16'h7c00;
    localparam logic [15:0] IEEE16_NINF    = 16'hfc00;
    localparam logic [7:0]  HALF_BIAS      = 8'd14;

endpackage

@@ src/dtrf_regs.sv @@
// Configuration register file with APB-style access.
module dtrf_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output dtrf_pkg::cfg_t      cfg
);
    import dtrf_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_GENERIC;
            cfg_reg.bias   <= 8'd128;
            cfg_reg.mbytes <= 3'd4;
            cfg_reg.offset <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MODE:   cfg_reg.mode   <= fmt_mode_t'(pwdata[2:0]);
                REG_BIAS:   cfg_reg.bias   <= pwdata[7:0];
                REG_MBYTES: cfg_reg.mbytes <= pwdata[2:0];
                REG_OFFSET: cfg_reg.offset <= pwdata[0];
                default:    cfg_reg.offset <= cfg_reg.offset;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            REG_MODE:   prdata = {29'd0, cfg_reg.mode};
            REG_BIAS:   prdata = {24'd0, cfg_reg.bias};
            REG_MBYTES: prdata = {29'd0, cfg_reg.mbytes};
            REG_OFFSET: prdata = {31'd0, cfg_reg.offset};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

@@ src/dtrf_convert.sv @@
// Combinational conversion of one binary64 pattern into the selected byte format.
module dtrf_convert (
    input  dtrf_pkg::cfg_t  cfg,
    input  logic [63:0]     double_bits,
    output logic [63:0]     packed_bytes,
    output logic [3:0]      byte_count
);
    import dtrf_pkg::*;

    logic [10:0] ef;
    logic [51:0] f;
    logic        s, is_nan, is_inf, is_zero, fin;
    logic [7:0]  bias;
    logic [2:0]  mb;
    logic [5:0]  lead;
    logic [63:0] m;
    logic [12:0] e;
    logic [5:0]  nb;
    logic [56:0] k;
    logic [55:0] top, kc, t;
    logic        rb;
    logic [7:0]  xb;
    logic [63:0] r, g;
    logic [3:0]  cnt;

    always_comb
    begin
        ef = double_bits[62:52];
        f  = double_bits[51:0];
        s  = double_bits[63];
        is_nan  = (ef == 11'h7ff) && (f != 52'd0);
        is_inf  = (ef == 11'h7ff) && (f == 52'd0);
        is_zero = (ef == 11'd0) && (f == 52'd0);
        fin     = !is_nan && !is_inf && !is_zero;

        bias = cfg.bias;
        mb   = (cfg.mbytes == 3'd0) ? 3'd1 : cfg.mbytes;
        if (cfg.mode == MODE_IEEE16)
        begin
            bias = HALF_BIAS;
            mb   = 3'd2;
        end

        // leading-one search for subnormals (priority encoder)
        lead = 6'd0;
        for (int i = 1; i < 52; i++)
            if (f[i])
                lead = 6'(i);

        // normalize: hidden bit to bit 63, e = p + 1
        if (ef == 11'd0)
        begin
            m = {12'd0, f} << (7'd63 - {1'b0, lead});
            e = 13'({7'd0, lead}) - 13'd1073;
        end
        else
        begin
            m = {1'b1, f, 11'd0};
            e = 13'({2'd0, ef}) - 13'd1022;
        end

        nb  = {mb, 3'b000};
        k   = 57'(m >> (7'd64 - {1'b0, nb}));
        rb  = m[6'd63 - nb];
        top = 56'd1 << (nb - 6'd1);
        k   = k + 57'(rb);
        if ((k >> nb) != 57'd0)
        begin
            k = {1'b0, top};
            e = e + 13'd1;
        end
        kc = k[55:0] & ~top;
        xb = e[7:0] + bias;
        t  = kc << ({3'd7 - mb, 3'b000});

        r   = 64'd0;
        g   = 64'd0;
        cnt = 4'd4;
        case (cfg.mode)
            MODE_IEEE32:
            begin
                if (is_nan)      r = {32'd0, IEEE32_NAN};
                else if (is_inf) r = {32'd0, s ? IEEE32_NINF : IEEE32_PINF};
                else if (fin)    r = {32'd0, s, xb, t[54:32]};
            end
            MODE_IEEE16:
            begin
                cnt = 4'd2;
                if (is_nan)      r = {48'd0, IEEE16_NAN};
                else if (is_inf) r = {48'd0, s ? IEEE16_NINF : IEEE16_PINF};
                else if (fin)    r = {48'd0, s, xb[4:0], kc[14:5]};
            end
            MODE_MBF32:
                if (fin) r = {32'd0, xb, s, t[54:32]};
            MODE_AM9511:
                if (fin) r = {32'd0, s, xb[6:0], t[55:32] | 24'h800000};
            MODE_MBF40:
            begin
                cnt = 4'd5;
                if (fin) r = {24'd0, xb, s, t[54:24]};
            end
            MODE_MBF64:
            begin
                cnt = 4'd8;
                if (fin) r = {xb, s, t[54:0]};
            end
            default:
            begin
                cnt = 4'({3'd0, cfg.offset}) + 4'({1'b0, mb}) + 4'd1;
                if (cnt > 4'd8)
                    cnt = 4'd8;
                if (fin)
                begin
                    g = {8'd0, kc} | ({63'd0, s} << (nb - 6'd1))
                        | ({56'd0, xb} << nb);
                    r = cfg.offset ? {g[55:0], 8'd0} : g;
                end
            end
        endcase
        packed_bytes = r;
        byte_count   = cnt;
    end

endmodule

@@ src/double_to_retro_float_format.sv @@
// Top level: binary64 to retro float byte format converter.
//
// Input channel (in_valid/in_ready, double_bits) takes one binary64 pattern
// per transfer. Output channel (out_valid/out_ready, packed_bytes,
// byte_count) gives one result per input, in order.
// The conversion is single-pass logic from the input port into the result
// register; a result appears the cycle after its transfer in.
// Throughput is one item per cycle while results are taken. in_ready is high
// whenever the result register is empty or is being emptied in the same cycle.
// When the receiver stalls the result holds and in_ready drops; nothing is
// lost.
// Reset clears the result valid flag and loads the register defaults:
// generic format, bias 128, four mantissa bytes, offset 0.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12
// (format_mode, exponent_bias, mantissa_bytes, byte_offset); write it only
// when the block is idle.
module double_to_retro_float_format (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] double_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] packed_bytes,
    output logic [3:0]  byte_count
);
    import dtrf_pkg::*;

    cfg_t        cfg;
    logic [63:0] conv_bytes;
    logic [3:0]  conv_count;
    logic        valid_reg;
    logic [63:0] bytes_reg;
    logic [3:0]  count_reg;

    dtrf_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    dtrf_convert u_conv (
        .cfg(cfg), .double_bits(double_bits),
        .packed_bytes(conv_bytes), .byte_count(conv_count)
    );

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // load result on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            bytes_reg <= conv_bytes;
            count_reg <= conv_count;
        end
    end

    assign out_valid    = valid_reg;
    assign packed_bytes = bytes_reg;
    assign byte_count   = count_reg;

endmodule

@@ src/dtrf_checker.sv @@
// Port-level checker for the converter, bound to the top level.
module dtrf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] packed_bytes,
    input logic [3:0]  byte_count
);
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("result missing after input transfer");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count >= 4'd2 && byte_count <= 4'd8))
        else $error("byte count out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packed_bytes))
        else $error("stalled result changed");
endmodule

bind double_to_retro_float_format dtrf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .packed_bytes(packed_bytes), .byte_count(byte_count)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the binary64 to retro float format converter.
`timescale 1ns / 100ps

module testbench;
    import dtrf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] double_bits = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] packed_bytes;
    logic [3:0]  byte_count;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
    } conv_t;

    typedef struct {
        logic [63:0] bits;
        logic        fixed;
        conv_t       res;
    } row_t;

    fmt_mode_t   cur_mode;
    logic [7:0]  cur_bias;
    logic [2:0]  cur_mbytes;
    logic        cur_offset;

    conv_t       pending[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    logic        timed_out = 1'b0;
    logic        rx_enable = 1'b0;

    localparam int WATCHDOG = 20000;

    always #2 clk = ~clk;

    double_to_retro_float_format u_dut (.*);

    // Compute the expected conversion for the current register settings.
    function automatic conv_t convert_double(input logic [63:0] b);
        conv_t       r;
        logic [10:0] ef;
        logic [51:0] f;
        logic        s;
        logic        nan, inf, zero, fin;
        int          mb, bias, nb, lead, e;
        logic [63:0] m, k, top, kc, t, w;
        logic [7:0]  xb;
        ef = b[62:52];
        f = b[51:0];
        s = b[63];
        nan = (ef == 11'h7ff) && (f != 0);
        inf = (ef == 11'h7ff) && (f == 0);
        zero = (ef == 0) && (f == 0);
        fin = !nan && !inf && !zero;
        mb = (cur_mbytes == 0) ? 1 : cur_mbytes;
        bias = cur_bias;
        if (cur_mode == MODE_IEEE16)
        begin
            bias = HALF_BIAS;
            mb = 2;
        end
        nb = 8 * mb;
        kc = '0;
        xb = '0;
        if (fin)
        begin
            if (ef == 0)
            begin
                lead = 51;
                while (lead > 0 && f[lead] == 1'b0)
                    lead--;
                m = {12'b0, f} << (52 - lead);
                e = lead - 1074 + 1;
            end
            else
            begin
                m = {11'b1, f};
                e = int'(ef) - 1023 + 1;
            end
            m = m << 11;
            k = m >> (64 - nb);
            k = k + ((m >> (63 - nb)) & 64'd1);
            top = 64'd1 << (nb - 1);
            if ((k >> nb) != 0)
            begin
                k = top;
                e++;
            end
            kc = k & ~top;
            xb = 8'(e + bias);
        end
        t = kc << (8 * (7 - mb));
        w = '0;
        case (cur_mode)
            MODE_IEEE32:
            begin
                r.count = 4;
                if (nan) w = 64'(IEEE32_NAN);
                else if (inf) w = s ? 64'(IEEE32_NINF) : 64'(IEEE32_PINF);
                else if (fin) w = (t[63:32] & 64'h7fffff) | (64'(xb) << 23) | (64'(s) << 31);
            end
            MODE_IEEE16:
            begin
                r.count = 2;
                if (nan) w = 64'(IEEE16_NAN);
                else if (inf) w = s ? 64'(IEEE16_NINF) : 64'(IEEE16_PINF);
                else if (fin)
                    w = ((kc >> 5) & 64'h3ff) | (64'(xb[4:0]) << 10) | (64'(s) << 15);
            end
            MODE_MBF32:
            begin
                r.count = 4;
                if (fin) w = (t[63:32] & 64'h7fffff) | (64'(s) << 23) | (64'(xb) << 24);
            end
            MODE_AM9511:
            begin
                r.count = 4;
                if (fin)
                    w = (t[63:32] & 64'hffffff) | 64'h800000 | (64'(xb[6:0]) << 24)
                        | (64'(s) << 31);
            end
            MODE_MBF40:
            begin
                r.count = 5;
                if (fin) w = ((t >> 24) & 64'hffffffff) | (64'(s) << 31) | (64'(xb) << 32);
            end
            MODE_MBF64:
            begin
                r.count = 8;
                if (fin) w = t | (64'(s) << 55) | (64'(xb) << 56);
            end
            default:
            begin
                r.count = (cur_offset + mb + 1 > 8) ? 4'd8 : 4'(cur_offset + mb + 1);
                if (fin)
                begin
                    w = kc | (64'(s) << (nb - 1)) | (64'(xb) << nb);
                    w = w << (8 * cur_offset);
                end
            end
        endcase
        r.bytes = w;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_MODE:   cur_mode = fmt_mode_t'(val[2:0]);
            REG_BIAS:   cur_bias = val[7:0];
            REG_MBYTES: cur_mbytes = val[2:0];
            default:    cur_offset = val[0];
        endcase
    endtask

    task automatic set_config(input fmt_mode_t md, input logic [7:0] bs,
                              input logic [2:0] mbn, input logic off);
        write_reg(REG_MODE, 32'(md));
        write_reg(REG_BIAS, 32'(bs));
        write_reg(REG_MBYTES, 32'(mbn));
        write_reg(REG_OFFSET, 32'(off));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic random_gap;
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
            in_valid <= 1'b0;
        repeat (g) @(posedge clk);
    endtask

    // Hold the item until the transfer happens.
    task automatic send_double(input logic [63:0] b, input logic fixed, input conv_t res);
        conv_t exp_res;
        exp_res = fixed ? res : convert_double(b);
        in_valid <= 1'b1;
        double_bits <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending.push_back(exp_res);
    endtask

    function automatic logic [63:0] random_double;
        logic [63:0] b;
        int          kind;
        b = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (kind == 0) b[62:52] = 11'h7ff;
        else if (kind == 1) b[62:52] = 11'h000;
        else if (kind == 2) b[51:0] = {2'($urandom_range(0, 3)), 50'h3ffffffffffff};
        else if (kind == 3) b[62:0] = 63'h0;
        else if (kind <= 6) b[62:52] = 11'(1023 + $signed($urandom_range(0, 300)) - 150);
        return b;
    endfunction

    // Check each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result bytes=%h count=%0d", packed_bytes, byte_count);
            end
            else
            begin
                if (packed_bytes !== pending[0].bytes || byte_count !== pending[0].count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d got %h/%0d", pending[0].bytes,
                                 pending[0].count, packed_bytes, byte_count);
                end
                void'(pending.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_enable)
            out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    row_t dir_rows[] = '{
        '{64'h0000000000000000, 1'b1, '{64'h0, 4'd5}},
        '{64'h8000000000000000, 1'b1, '{64'h0, 4'd5}},
        '{64'h3ff0000000000000, 1'b1, '{64'h0000008100000000, 4'd5}},
        '{64'hbff0000000000000, 1'b1, '{64'h0000008180000000, 4'd5}},
        '{64'h7ff0000000000000, 1'b1, '{64'h0, 4'd5}},
        '{64'h7ff8000000000000, 1'b1, '{64'h0, 4'd5}},
        '{64'h0000000000000001, 1'b0, '{64'h0, 4'd0}},
        '{64'h000fffffffffffff, 1'b0, '{64'h0, 4'd0}},
        '{64'h7fefffffffffffff, 1'b0, '{64'h0, 4'd0}},
        '{64'hffefffffffffffff, 1'b0, '{64'h0, 4'd0}},
        '{64'h3fefffffffffffff, 1'b0, '{64'h0, 4'd0}},
        '{64'h4000000000000000, 1'b0, '{64'h0, 4'd0}},
        '{64'h3fe0000080000000, 1'b0, '{64'h0, 4'd0}},
        '{64'hffffffffffffffff, 1'b0, '{64'h0, 4'd0}}
    };

    fmt_mode_t dir_modes[] = '{MODE_IEEE32, MODE_IEEE16, MODE_MBF32, MODE_MBF40,
                               MODE_MBF64, MODE_AM9511, MODE_SPARE};

    initial
    begin
        conv_t none;
        int    n;
        none = '0;
        cur_mode = MODE_GENERIC;
        cur_bias = 8'd128;
        cur_mbytes = 3'd4;
        cur_offset = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults first, then every mode with the same table.
        foreach (dir_rows[i])
            send_double(dir_rows[i].bits, dir_rows[i].fixed, dir_rows[i].res);
        drain();
        foreach (dir_modes[j])
        begin
            set_config(dir_modes[j], 8'd128, 3'd4, 1'b0);
            foreach (dir_rows[i])
                send_double(dir_rows[i].bits, 1'b0, none);
            drain();
        end
        set_config(MODE_GENERIC, 8'd255, 3'd7, 1'b1);
        foreach (dir_rows[i])
            send_double(dir_rows[i].bits, 1'b0, none);
        drain();
        set_config(MODE_GENERIC, 8'd0, 3'd0, 1'b1);
        foreach (dir_rows[i])
            send_double(dir_rows[i].bits, 1'b0, none);
        drain();

        rx_enable = 1'b1;
        for (int p = 0; p < 16; p++)
        begin
            if (p == 1)
                set_config(MODE_GENERIC, 8'd0, 3'd1, 1'b0);
            else if (p == 2)
                set_config(MODE_SPARE, 8'd255, 3'd7, 1'b1);
            else
                set_config(fmt_mode_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                           3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            n = (p == 0) ? 60 : 120;
            for (int i = 0; i < n; i++)
            begin
                random_gap();
                send_double(random_double(), 1'b0, none);
                if (i == 40 && p == 5)
                    drain();
            end
            drain();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
